/* sv/pdjm_pkg.sv */
// Package for the periodic deadline and jitter monitor.
// Widths, constants, opcodes, sequencer states, divider status and result structs.
// No dependencies; every other file of the block uses it.
package pdjm_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned RATE_W   = 30;
    localparam int unsigned OP_W     = 2;

    localparam logic [TIME_W-1:0]   ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0]   RATE_NUM     = 32'd1_000_000_000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;

    // Request kinds
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_ALARM = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } state_t;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // One result
    typedef struct packed {
        logic [TIME_W-1:0]        next_deadline_us;
        logic [TIME_W-1:0]        tick_total;
        logic [TIME_W-1:0]        missed_total;
        logic [TIME_W-1:0]        min_period_us;
        logic [TIME_W-1:0]        max_period_us;
        logic [TIME_W-1:0]        max_exec_us;
        logic signed [TIME_W-1:0] jitter_us;
        logic [RATE_W-1:0]        rate_millihertz;
    } rsp_t;

endpackage

/* sv/pdjm_if.sv */
// Valid/ready channel interfaces of the monitor: event requests in, statistics out.
// Depends on pdjm_pkg for field widths.
interface pdjm_req_if;
    logic                           valid;
    logic                           ready;
    logic [pdjm_pkg::OP_W-1:0]      opcode;
    logic [pdjm_pkg::TIME_W-1:0]    timestamp_us;
    logic [pdjm_pkg::TIME_W-1:0]    exec_us;
    logic                           clear_stats;

    modport source (output valid, opcode, timestamp_us, exec_us, clear_stats, input ready);
    modport sink   (input valid, opcode, timestamp_us, exec_us, clear_stats, output ready);
endinterface

interface pdjm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pdjm_pkg::TIME_W-1:0]       next_deadline_us;
    logic [pdjm_pkg::TIME_W-1:0]       tick_total;
    logic [pdjm_pkg::TIME_W-1:0]       missed_total;
    logic [pdjm_pkg::TIME_W-1:0]       min_period_us;
    logic [pdjm_pkg::TIME_W-1:0]       max_period_us;
    logic [pdjm_pkg::TIME_W-1:0]       max_exec_us;
    logic signed [pdjm_pkg::TIME_W-1:0] jitter_us;
    logic [pdjm_pkg::RATE_W-1:0]       rate_millihertz;

    modport source (output valid, next_deadline_us, tick_total, missed_total, min_period_us,
                    max_period_us, max_exec_us, jitter_us, rate_millihertz, input ready);
    modport sink   (input valid, next_deadline_us, tick_total, missed_total, min_period_us,
                    max_period_us, max_exec_us, jitter_us, rate_millihertz, output ready);
endinterface

/* sv/pdjm_div.sv */
// Shared restoring divider, one quotient bit per cycle, then raises done.
// Depends on pdjm_pkg for the status struct and widths.
module pdjm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pdjm_pkg::TIME_W-1:0]   dividend,
    input  logic [pdjm_pkg::TIME_W-1:0]   divisor,
    output pdjm_pkg::div_stat_t           stat,
    output logic [pdjm_pkg::TIME_W-1:0]   quotient,
    output logic [pdjm_pkg::TIME_W-1:0]   remainder
);
    import pdjm_pkg::*;

    localparam int unsigned CNT_W = $clog2(TIME_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   trial;

    // One shift-and-subtract step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[TIME_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[TIME_W])
            begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath flops
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/periodic_deadline_jitter_monitor.sv */
// Channel   | Dir | Payload                                                  | Handshake
// sample    | in  | opcode, timestamp_us, exec_us, clear_stats               | valid/ready
// report    | out | deadline, tick/missed totals, min/max, exec, jitter, rate | valid/ready
// cfg       | in  | cfg_wdata = period_us (20 bits)                          | cfg_we, no stall
//
// Start, no-op, a future alarm and a tick without a statistic update go from accept
// straight to the write state. A late alarm and a statistic tick use the shared 32-step
// divider (lag / period or 1e9 / measured period) in the divide state before the write.
// sample.ready is high only in the idle state; a finished result waits in the output
// register while the next request is taken. Reset is asynchronous, active low.
//
// Top level of the periodic deadline and jitter monitor.
// Depends on pdjm_pkg, pdjm_if (pdjm_req_if, pdjm_rsp_if) and pdjm_div.
module periodic_deadline_jitter_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    pdjm_req_if.sink                        sample,
    pdjm_rsp_if.source                      report,
    input  logic                            cfg_we,
    input  logic [pdjm_pkg::PERIOD_W-1:0]   cfg_wdata
);
    import pdjm_pkg::*;

    state_t              state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   deadline_reg, deadline_next;
    logic [TIME_W-1:0]   missed_reg, missed_next;
    logic [TIME_W-1:0]   last_stamp_reg, last_stamp_next;
    logic                seen_reg, seen_next;
    logic [TIME_W-1:0]   tick_reg, tick_next;
    logic [TIME_W-1:0]   min_period_reg, min_period_next;
    logic [TIME_W-1:0]   max_period_reg, max_period_next;
    logic [TIME_W-1:0]   max_exec_reg, max_exec_next;
    logic [TIME_W-1:0]   jitter_reg, jitter_next;
    logic [RATE_W-1:0]   last_rate_reg, last_rate_next;
    logic                alarm_div_reg, alarm_div_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [TIME_W-1:0]   eff_period;
    logic [TIME_W-1:0]   first;
    logic [TIME_W-1:0]   diff;
    logic [TIME_W-1:0]   per;
    logic [TIME_W-1:0]   base_min;
    logic [TIME_W-1:0]   base_max;
    logic [TIME_W-1:0]   base_exec;
    logic [TIME_W-1:0]   base_tick;
    logic [TIME_W-1:0]   base_missed;
    logic                base_seen;
    logic                accept;
    logic                div_start;
    logic [TIME_W-1:0]   div_dividend;
    logic [TIME_W-1:0]   div_divisor;
    div_stat_t           div_stat;
    logic [TIME_W-1:0]   div_quo;
    logic [TIME_W-1:0]   div_rem;

    // Shared divider
    pdjm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Period register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            period_reg <= cfg_wdata;
        end
    end

    // Values shared by the request arms
    always_comb
    begin
        eff_period  = (period_reg == '0) ? TIME_W'(1) : TIME_W'(period_reg);
        first       = deadline_reg + eff_period;
        diff        = first - sample.timestamp_us;
        per         = sample.timestamp_us - last_stamp_reg;
        base_min    = sample.clear_stats ? ALL_ONES : min_period_reg;
        base_max    = sample.clear_stats ? '0 : max_period_reg;
        base_exec   = sample.clear_stats ? '0 : max_exec_reg;
        base_tick   = sample.clear_stats ? '0 : tick_reg;
        base_missed = sample.clear_stats ? '0 : missed_reg;
        base_seen   = sample.clear_stats ? 1'b0 : seen_reg;
    end

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);

    // Sequencer: next state and state updates
    always_comb
    begin
        state_next      = state_reg;
        deadline_next   = deadline_reg;
        missed_next     = missed_reg;
        last_stamp_next = last_stamp_reg;
        seen_next       = seen_reg;
        tick_next       = tick_reg;
        min_period_next = min_period_reg;
        max_period_next = max_period_reg;
        max_exec_next   = max_exec_reg;
        jitter_next     = jitter_reg;
        last_rate_next  = last_rate_reg;
        alarm_div_next  = alarm_div_reg;
        now_next        = now_reg;
        out_valid_next  = out_valid_reg && !report.ready;
        rsp_next        = rsp_reg;
        div_start       = 1'b0;
        div_dividend    = sample.timestamp_us - first;
        div_divisor     = eff_period;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WRITE;
                    unique case (opcode_t'(sample.opcode))
                        OP_START:
                        begin
                            deadline_next   = sample.timestamp_us + eff_period;
                            last_stamp_next = sample.timestamp_us;
                            seen_next       = 1'b0;
                        end
                        OP_ALARM:
                        begin
                            if (diff != '0 && !diff[TIME_W-1])
                            begin
                                deadline_next = first;
                            end
                            else
                            begin
                                // late: divide the lag by the period
                                div_start      = 1'b1;
                                alarm_div_next = 1'b1;
                                now_next       = sample.timestamp_us;
                                state_next     = ST_DIV;
                            end
                        end
                        OP_TICK:
                        begin
                            min_period_next = base_min;
                            max_period_next = base_max;
                            max_exec_next   = base_exec;
                            missed_next     = base_missed;
                            tick_next       = base_tick + 1'b1;
                            last_stamp_next = sample.timestamp_us;
                            seen_next       = 1'b1;
                            if (base_seen && per != '0)
                            begin
                                jitter_next = per - TIME_W'(period_reg);
                                if (per < base_min)
                                begin
                                    min_period_next = per;
                                end
                                if (per > base_max)
                                begin
                                    max_period_next = per;
                                end
                                if (sample.exec_us > base_exec)
                                begin
                                    max_exec_next = sample.exec_us;
                                end
                                div_start      = 1'b1;
                                div_dividend   = RATE_NUM;
                                div_divisor    = per;
                                alarm_div_next = 1'b0;
                                state_next     = ST_DIV;
                            end
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (alarm_div_reg)
                    begin
                        // deadline = first + (q + 1) * p = now - r + p
                        deadline_next = now_reg - div_rem + eff_period;
                        missed_next   = missed_reg + div_quo + 1'b1;
                    end
                    else
                    begin
                        last_rate_next = div_quo[RATE_W-1:0];
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || report.ready)
                begin
                    rsp_next.next_deadline_us = deadline_reg;
                    rsp_next.tick_total       = tick_reg;
                    rsp_next.missed_total     = missed_reg;
                    rsp_next.min_period_us    = min_period_reg;
                    rsp_next.max_period_us    = max_period_reg;
                    rsp_next.max_exec_us      = max_exec_reg;
                    rsp_next.jitter_us        = jitter_reg;
                    rsp_next.rate_millihertz  = last_rate_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            deadline_reg   <= '0;
            missed_reg     <= '0;
            last_stamp_reg <= '0;
            seen_reg       <= 1'b0;
            tick_reg       <= '0;
            min_period_reg <= ALL_ONES;
            max_period_reg <= '0;
            max_exec_reg   <= '0;
            jitter_reg     <= '0;
            last_rate_reg  <= '0;
            alarm_div_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            deadline_reg   <= deadline_next;
            missed_reg     <= missed_next;
            last_stamp_reg <= last_stamp_next;
            seen_reg       <= seen_next;
            tick_reg       <= tick_next;
            min_period_reg <= min_period_next;
            max_period_reg <= max_period_next;
            max_exec_reg   <= max_exec_next;
            jitter_reg     <= jitter_next;
            last_rate_reg  <= last_rate_next;
            alarm_div_reg  <= alarm_div_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        rsp_reg <= rsp_next;
    end

    // Result channel
    assign report.valid            = out_valid_reg;
    assign report.next_deadline_us = rsp_reg.next_deadline_us;
    assign report.tick_total       = rsp_reg.tick_total;
    assign report.missed_total     = rsp_reg.missed_total;
    assign report.min_period_us    = rsp_reg.min_period_us;
    assign report.max_period_us    = rsp_reg.max_period_us;
    assign report.max_exec_us      = rsp_reg.max_exec_us;
    assign report.jitter_us        = rsp_reg.jitter_us;
    assign report.rate_millihertz  = rsp_reg.rate_millihertz;

`ifndef ASSERT_OFF
    // No new request while the divider is working
    a_busy_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !sample.ready)
        else $error("request accepted while divider busy");

    // Divider completes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // Once a valid period is recorded, min never exceeds max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (min_period_reg != ALL_ONES) |-> (min_period_reg <= max_period_reg))
        else $error("min period above max period");

    // Rate never exceeds the numerator
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        (TIME_W'(last_rate_reg) <= RATE_NUM))
        else $error("rate out of range");
`endif

endmodule

/* sim/tb_periodic_deadline_jitter_monitor.sv */
// Self-checking testbench for periodic_deadline_jitter_monitor: directed cases, then
// random loop traffic under several period settings, checked against an in-bench predictor.
// Depends on pdjm_pkg, pdjm_if and the monitor RTL.
module tb_periodic_deadline_jitter_monitor;
    import pdjm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned CFG_SETTLE     = 4;
    localparam int unsigned LOOP_ITEMS     = 136;

    // One pending entry: a sample request or a period register write
    typedef struct {
        bit                  is_cfg;
        logic [PERIOD_W-1:0] cfg_val;
        opcode_t             op;
        logic [TIME_W-1:0]   ts;
        logic [TIME_W-1:0]   ex;
        logic                clr;
    } sample_req_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;

    pdjm_req_if sample_if ();
    pdjm_rsp_if report_if ();

    periodic_deadline_jitter_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .report    (report_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_req_t sample_q[$];
    rsp_t        expected_reports[$];
    sample_req_t in_flight;
    rsp_t        want_report;

    int unsigned req_accepts = 0;
    int unsigned rsp_accepts = 0;
    int unsigned mismatches  = 0;
    int unsigned send_gap    = 0;
    int unsigned send_calm   = 0;
    int unsigned cfg_settle  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_calm  = 0;
    int unsigned idle_cycles = 0;
    int unsigned last_seen   = 0;
    logic        valid_nxt;
    logic        we_nxt;

    // Predicted block state, reset values
    logic [PERIOD_W-1:0] target_period   = PERIOD_RESET;
    logic [TIME_W-1:0]   pred_deadline   = '0;
    logic [TIME_W-1:0]   pred_missed     = '0;
    logic [TIME_W-1:0]   pred_last_stamp = '0;
    logic                pred_have_ref   = 1'b0;
    logic [TIME_W-1:0]   pred_ticks      = '0;
    logic [TIME_W-1:0]   pred_min        = ALL_ONES;
    logic [TIME_W-1:0]   pred_max        = '0;
    logic [TIME_W-1:0]   pred_max_exec   = '0;
    logic [TIME_W-1:0]   pred_jitter     = '0;
    logic [TIME_W-1:0]   pred_rate       = '0;

    // Apply one request to the predicted state and return the report it produces
    function automatic rsp_t predict_report(sample_req_t r);
        logic [TIME_W-1:0] inc;
        logic [TIME_W-1:0] first_due;
        logic [TIME_W-1:0] ahead;
        logic [TIME_W-1:0] lag;
        logic [TIME_W-1:0] extra;
        logic [TIME_W-1:0] per;
        rsp_t              e;
        // a zero period register acts as one for deadline math
        inc = (target_period == '0) ? 32'd1 : {12'd0, target_period};
        case (r.op)
            OP_START:
            begin
                pred_deadline   = r.ts + inc;
                pred_last_stamp = r.ts;
                pred_have_ref   = 1'b0;
            end
            OP_ALARM:
            begin
                first_due = pred_deadline + inc;
                ahead     = first_due - r.ts;
                if (ahead != '0 && ahead < 32'h8000_0000)
                    pred_deadline = first_due;
                else
                begin
                    // catch up past now, every extra period is a miss
                    lag           = r.ts - first_due;
                    extra         = lag / inc + 32'd1;
                    pred_deadline = first_due + extra * inc;
                    pred_missed   = pred_missed + extra;
                end
            end
            OP_TICK:
            begin
                if (r.clr)
                begin
                    pred_min      = ALL_ONES;
                    pred_max      = '0;
                    pred_max_exec = '0;
                    pred_ticks    = '0;
                    pred_missed   = '0;
                    pred_have_ref = 1'b0;
                end
                per             = r.ts - pred_last_stamp;
                pred_last_stamp = r.ts;
                pred_ticks      = pred_ticks + 32'd1;
                if (pred_have_ref && per != '0)
                begin
                    pred_jitter = per - {12'd0, target_period};
                    if (per < pred_min)
                        pred_min = per;
                    if (per > pred_max)
                        pred_max = per;
                    if (r.ex > pred_max_exec)
                        pred_max_exec = r.ex;
                    pred_rate = RATE_NUM / per;
                end
                pred_have_ref = 1'b1;
            end
            default:
            begin
            end
        endcase
        e.next_deadline_us = pred_deadline;
        e.tick_total       = pred_ticks;
        e.missed_total     = pred_missed;
        e.min_period_us    = pred_min;
        e.max_period_us    = pred_max;
        e.max_exec_us      = pred_max_exec;
        e.jitter_us        = pred_jitter;
        e.rate_millihertz  = pred_rate[RATE_W-1:0];
        return e;
    endfunction

    // Gap length: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 70);
    endfunction

    function automatic void check_field(string what, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("report %0d: %s expected %h, got %h", rsp_accepts, what, want, got);
        end
    endfunction

    task automatic push_sample(opcode_t op, logic [TIME_W-1:0] ts, logic [TIME_W-1:0] ex,
                               logic clr);
        sample_req_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.op      = op;
        r.ts      = ts;
        r.ex      = ex;
        r.clr     = clr;
        sample_q.push_back(r);
    endtask

    // Period write; the driver holds it until every report is back
    task automatic push_period(logic [PERIOD_W-1:0] v);
        sample_req_t r;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        r.op      = OP_NOP;
        r.ts      = '0;
        r.ex      = '0;
        r.clr     = 1'b0;
        sample_q.push_back(r);
    endtask

    // A run of periodic loop traffic: start, then alarm/tick pairs with jitter,
    // missed periods, restarts, repeated stamps, clears and some random noise
    task automatic add_loop_phase(logic [PERIOD_W-1:0] cfg_val, int unsigned n_items);
        logic [TIME_W-1:0] inc;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] tick_ts;
        logic [TIME_W-1:0] exec;
        int unsigned       made;
        int unsigned       r;
        inc     = (cfg_val == '0) ? 32'd1 : {12'd0, cfg_val};
        now     = $urandom;
        tick_ts = now;
        push_period(cfg_val);
        push_sample(OP_START, now, $urandom, $urandom_range(0, 1) == 1);
        made = 1;
        while (made < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                push_sample(opcode_t'($urandom_range(0, 3)), $urandom, $urandom,
                            $urandom_range(0, 1) == 1);
                made++;
            end
            else if (r < 14)
            begin
                now = now + $urandom_range(0, inc);
                push_sample(OP_START, now, $urandom, 1'b0);
                made++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    now = now + inc + $urandom_range(0, inc / 4) - inc / 8;
                else if (r < 95)
                    now = now + inc * $urandom_range(2, 12);
                else
                    now = now + $urandom_range(32'h7FF0_0000, 32'h8000_0000);
                push_sample(OP_ALARM, now, $urandom, $urandom_range(0, 1) == 1);
                r = $urandom_range(0, 99);
                if (r < 55)
                    exec = $urandom_range(0, inc);
                else if (r < 90)
                    exec = $urandom;
                else
                    exec = (r < 95) ? 32'd0 : ALL_ONES;
                // now and then repeat the previous stamp for a zero period
                if ($urandom_range(0, 24) != 0)
                    tick_ts = now + $urandom_range(0, inc / 8);
                push_sample(OP_TICK, tick_ts, exec, $urandom_range(0, 39) == 0);
                made += 2;
            end
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid        <= 1'b0;
            sample_if.opcode       <= '0;
            sample_if.timestamp_us <= '0;
            sample_if.exec_us      <= '0;
            sample_if.clear_stats  <= 1'b0;
            cfg_we                 <= 1'b0;
            cfg_wdata              <= '0;
            send_gap   = 0;
            cfg_settle = 0;
        end
        else
        begin
            valid_nxt = sample_if.valid;
            we_nxt    = 1'b0;
            if (sample_if.valid && sample_if.ready)
            begin
                expected_reports.push_back(predict_report(in_flight));
                req_accepts++;
                valid_nxt = 1'b0;
                // gap before the next request, with calm stretches of none
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else if ($urandom_range(0, 39) == 0)
                begin
                    send_calm = $urandom_range(20, 80);
                    send_gap  = 0;
                end
                else
                    send_gap = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end
            if (!valid_nxt)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (sample_q.size() != 0)
                begin
                    if (sample_q[0].is_cfg)
                    begin
                        // write the period only once the block has drained
                        if (expected_reports.size() != 0)
                            cfg_settle = 0;
                        else if (cfg_settle < CFG_SETTLE)
                            cfg_settle++;
                        else
                        begin
                            in_flight     = sample_q.pop_front();
                            cfg_wdata     <= in_flight.cfg_val;
                            we_nxt        = 1'b1;
                            target_period = in_flight.cfg_val;
                            cfg_settle    = 0;
                        end
                    end
                    else
                    begin
                        in_flight              = sample_q.pop_front();
                        sample_if.opcode       <= in_flight.op;
                        sample_if.timestamp_us <= in_flight.ts;
                        sample_if.exec_us      <= in_flight.ex;
                        sample_if.clear_stats  <= in_flight.clr;
                        valid_nxt              = 1'b1;
                    end
                end
            end
            sample_if.valid <= valid_nxt;
            cfg_we          <= we_nxt;
        end
    end

    // Report monitor and checker, with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_if.ready <= 1'b0;
            stall_left = 0;
            stall_calm = 0;
        end
        else
        begin
            if (report_if.valid && report_if.ready)
            begin
                rsp_accepts++;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report %0d: none expected, got deadline %h ticks %h",
                                 rsp_accepts, report_if.next_deadline_us,
                                 report_if.tick_total);
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    check_field("next_deadline_us", want_report.next_deadline_us,
                                report_if.next_deadline_us);
                    check_field("tick_total", want_report.tick_total, report_if.tick_total);
                    check_field("missed_total", want_report.missed_total,
                                report_if.missed_total);
                    check_field("min_period_us", want_report.min_period_us,
                                report_if.min_period_us);
                    check_field("max_period_us", want_report.max_period_us,
                                report_if.max_period_us);
                    check_field("max_exec_us", want_report.max_exec_us,
                                report_if.max_exec_us);
                    check_field("jitter_us", want_report.jitter_us, report_if.jitter_us);
                    check_field("rate_millihertz", {2'b00, want_report.rate_millihertz},
                                {2'b00, report_if.rate_millihertz});
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (stall_calm > 0)
                stall_calm--;
            else if ($urandom_range(0, 59) == 0)
                stall_calm = $urandom_range(40, 200);
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            report_if.ready <= (stall_left == 0);
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_accepts + rsp_accepts == last_seen)
                idle_cycles++;
            else
            begin
                idle_cycles = 0;
                last_seen   = req_accepts + rsp_accepts;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("periodic_deadline_jitter_monitor test failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        sample_if.valid        = 1'b0;
        sample_if.opcode       = '0;
        sample_if.timestamp_us = '0;
        sample_if.exec_us      = '0;
        sample_if.clear_stats  = 1'b0;
        report_if.ready        = 1'b0;

        // Directed, reset period of 1000
        push_sample(OP_NOP, ALL_ONES, ALL_ONES, 1'b1);           // no-op reports reset state
        push_sample(OP_TICK, 32'd0, 32'd5, 1'b0);                // first tick takes a reference
        push_sample(OP_TICK, 32'd0, 32'd9, 1'b0);                // zero measured period
        push_sample(OP_TICK, 32'd1000, ALL_ONES, 1'b0);          // on target
        push_sample(OP_TICK, 32'd1001, 32'd0, 1'b0);             // one us: top rate
        push_sample(OP_TICK, 32'd1000, 32'd3, 1'b0);             // wrapped, all-ones period
        push_sample(OP_START, 32'hFFFF_FC18, 32'd0, 1'b0);       // deadline wraps to zero
        push_sample(OP_TICK, 32'd10, 32'd4, 1'b0);               // reference only after start
        push_sample(OP_ALARM, 32'd500, 32'd0, 1'b0);             // deadline in the future
        push_sample(OP_ALARM, 32'd2000, 32'd0, 1'b0);            // next deadline equals now
        push_sample(OP_ALARM, 32'h8000_0FA0, ALL_ONES, 1'b1);    // lag of exactly half the range
        push_sample(OP_ALARM, 32'd0, 32'd0, 1'b0);
        push_sample(OP_TICK, 32'd100, ALL_ONES, 1'b1);           // clear
        push_sample(OP_TICK, 32'd300, 32'd1, 1'b1);              // clear twice in a row
        push_sample(OP_TICK, 32'd1300, 32'd77, 1'b0);
        push_period(20'd0);                                      // zero period acts as one
        push_sample(OP_START, 32'h7FFF_FFFF, 32'd0, 1'b0);
        push_sample(OP_ALARM, 32'h8000_0005, 32'd0, 1'b0);
        push_sample(OP_TICK, 32'h8000_0005, 32'd2, 1'b0);
        push_sample(OP_TICK, 32'h8000_0009, 32'd8, 1'b0);
        push_period(20'hF_FFFF);                                 // widest period
        push_sample(OP_START, 32'd0, 32'd0, 1'b0);
        push_sample(OP_ALARM, 32'h000F_FFFF, 32'd0, 1'b0);
        push_sample(OP_TICK, 32'd5, 32'd1, 1'b0);
        push_sample(OP_TICK, 32'h0010_0004, 32'h8000_0000, 1'b0);

        // Random loop traffic over several periods, extremes first
        add_loop_phase(20'd1000, LOOP_ITEMS);
        add_loop_phase(20'd1, LOOP_ITEMS);
        add_loop_phase(20'd0, LOOP_ITEMS);
        add_loop_phase(20'hF_FFFF, LOOP_ITEMS);
        add_loop_phase(20'd1_000_000, LOOP_ITEMS);
        repeat (7)
            add_loop_phase(PERIOD_W'(($urandom_range(0, 2) == 0) ? $urandom
                                                                 : $urandom_range(2, 5000)),
                           LOOP_ITEMS);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (sample_q.size() != 0 || sample_if.valid || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("periodic_deadline_jitter_monitor test passed");
        else
            $display("periodic_deadline_jitter_monitor test failed");
        $finish;
    end

endmodule
